>>> rtl/core/pc_sample_histogram_top_k_assert.svh
// Assertion macros shared by the profiler RTL.
`ifndef PC_SAMPLE_HISTOGRAM_TOP_K_ASSERT_SVH
`define PC_SAMPLE_HISTOGRAM_TOP_K_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PCH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define PCH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pch_pkg.sv
// Shared constants and codes of the PC sampling profiler.
`timescale 1ns / 1ps
package pch_pkg;

  localparam int unsigned NumBinsDefault = 4096;
  localparam int unsigned TopKDefault    = 10;

  localparam int unsigned CntW     = 32;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned RankOutW = 4;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [AddrW-1:0] TextBaseReset = 32'h0000_8000;
  localparam logic [CntW-1:0]  CntMax        = '1;

  // Item kinds carried in tuser
  localparam logic [FuncW-1:0] FuncSample = 2'd0;
  localparam logic [FuncW-1:0] FuncClear  = 2'd1;
  localparam logic [FuncW-1:0] FuncReport = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTextBase = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSampleEn = 2'd1;

  // Result status codes
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusNoRun = 1'b1;

endpackage

>>> rtl/core/pch_cell.sv
// One cell of the sorted top-K chain: holds a bin, passes the loser on.
`timescale 1ns / 1ps
module pch_cell #(
  parameter int unsigned IdxW = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    in_valid_i,
  input  logic [IdxW-1:0]         in_idx_i,
  input  logic [pch_pkg::CntW-1:0] in_cnt_i,
  output logic                    pass_valid_o,
  output logic [IdxW-1:0]         pass_idx_o,
  output logic [pch_pkg::CntW-1:0] pass_cnt_o,
  output logic [IdxW-1:0]         held_idx_o,
  output logic [pch_pkg::CntW-1:0] held_cnt_o
);

  logic                     held_valid_q;
  logic [IdxW-1:0]          held_idx_q;
  logic [pch_pkg::CntW-1:0] held_cnt_q;
  logic                     pass_valid_q;
  logic [IdxW-1:0]          pass_idx_q;
  logic [pch_pkg::CntW-1:0] pass_cnt_q;
  logic                     in_wins;

  // Incoming bin ranks higher on a larger count, or on an equal count at a lower bin
  assign in_wins = !held_valid_q || (in_cnt_i > held_cnt_q) ||
                   ((in_cnt_i == held_cnt_q) && (in_idx_i < held_idx_q));

  // Keep the higher-ranked bin, pass the other one down the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      pass_valid_q <= 1'b0;
    end else if (clr_i) begin
      held_valid_q <= 1'b0;
      pass_valid_q <= 1'b0;
    end else if (in_valid_i) begin
      if (!held_valid_q) begin
        held_valid_q <= 1'b1;
        pass_valid_q <= 1'b0;
      end else begin
        pass_valid_q <= 1'b1;
      end
    end else begin
      pass_valid_q <= 1'b0;
    end
  end

  // Payload: swap when the incoming bin wins
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      if (in_wins) begin
        held_idx_q <= in_idx_i;
        held_cnt_q <= in_cnt_i;
        pass_idx_q <= held_idx_q;
        pass_cnt_q <= held_cnt_q;
      end else begin
        pass_idx_q <= in_idx_i;
        pass_cnt_q <= in_cnt_i;
      end
    end
  end

  assign pass_valid_o = pass_valid_q;
  assign pass_idx_o   = pass_idx_q;
  assign pass_cnt_o   = pass_cnt_q;
  assign held_idx_o   = held_idx_q;
  assign held_cnt_o   = held_cnt_q;

endmodule

>>> rtl/core/pc_sample_histogram_top_k.sv
// Top level of the PC sampling profiler with a top-K report.
//
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   s_axis_tvalid_i/tready_o      tdata: sample_pc; tuser: func
//  m_axis    out  m_axis_tvalid_o/tready_i      tdata: rank,hot_pc,hit_count;
//                                               tuser: status; tlast: last
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A counted sample is a read-modify-write of its bin: read in S_IDLE, written
// back in S_RMW; an ignored sample or kind stays in S_IDLE. Clear sweeps all
// NUM_BINS bins. After a clear, report streams every bin through the K-cell
// sorting chain, then one result per transfer; with no clear yet, report
// gives one NoRun result. After reset every bin is cleared before the first
// item. One item is worked on at a time; output stalls hold the report.
`timescale 1ns / 1ps
`include "pc_sample_histogram_top_k_assert.svh"
module pc_sample_histogram_top_k #(
  parameter int unsigned NUM_BINS = pch_pkg::NumBinsDefault,
  parameter int unsigned TOP_K    = pch_pkg::TopKDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [31:0]                  s_axis_tdata_i,  // [31:0] sample_pc
  input  logic [1:0]                   s_axis_tuser_i,  // [1:0] func
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [71:0]                  m_axis_tdata_o,  // [3:0] rank, [35:4] hot_pc,
                                                        // [67:36] hit_count, [71:68] 0
  output logic                         m_axis_tuser_o,  // [0] status
  output logic                         m_axis_tlast_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pch_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  localparam int unsigned K      = (TOP_K < NUM_BINS) ? TOP_K : NUM_BINS;
  localparam int unsigned IdxW   = $clog2(NUM_BINS);
  localparam int unsigned SwW    = IdxW + 1;
  localparam int unsigned RkW    = (K > 1) ? $clog2(K) : 1;
  localparam int unsigned CntW   = pch_pkg::CntW;
  localparam int unsigned RkOutW = pch_pkg::RankOutW;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RMW, S_CLR, S_SCAN, S_DRAIN, S_EMIT
  } state_e;

  state_e             state_q;
  logic [SwW-1:0]     sweep_q;
  logic [RkW-1:0]     rank_q;
  logic               run_q;
  logic               err_q;
  logic [31:0]        base_q;
  logic               en_q;
  logic [IdxW-1:0]    word_q;
  logic               rd_v_q;
  logic [IdxW-1:0]    rd_idx_q;

  // Bin memory
  logic [CntW-1:0]    mem_q [NUM_BINS];
  logic [CntW-1:0]    rdata_q;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic [CntW-1:0]    wr_data;

  logic               in_xfer;
  logic               out_xfer;
  logic [32:0]        offset;
  logic               in_window;
  logic               cells_clr;
  logic               out_last;

  logic               chain_v   [K+1];
  logic [IdxW-1:0]    chain_idx [K+1];
  logic [CntW-1:0]    chain_cnt [K+1];
  logic [IdxW-1:0]    held_idx  [K];
  logic [CntW-1:0]    held_cnt  [K];

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;

  // Window check on the word offset from the text base
  assign offset    = {1'b0, s_axis_tdata_i} - {1'b0, base_q};
  assign in_window = !offset[32] && (offset[31:2] < 30'(NUM_BINS));

  assign cells_clr = in_xfer && (s_axis_tuser_i == pch_pkg::FuncReport) && run_q;
  assign out_last  = err_q || (rank_q == RkW'(K - 1));

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sweep_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = sweep_q[IdxW-1:0];
    wr_data = '0;
    case (state_q)
      S_IDLE: begin
        rd_en   = in_xfer && (s_axis_tuser_i == pch_pkg::FuncSample);
        rd_addr = offset[IdxW+1:2];
      end
      S_SCAN: rd_en = 1'b1;
      S_INIT, S_CLR: wr_en = 1'b1;
      S_RMW: begin
        wr_en   = (rdata_q != pch_pkg::CntMax);
        wr_addr = word_q;
        wr_data = rdata_q + CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sorting chain fed by the scan
  assign chain_v[0]   = rd_v_q;
  assign chain_idx[0] = rd_idx_q;
  assign chain_cnt[0] = rdata_q;

  for (genvar g = 0; g < K; g++) begin : g_cell
    pch_cell #(.IdxW(IdxW)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clr_i        (cells_clr),
      .in_valid_i   (chain_v[g]),
      .in_idx_i     (chain_idx[g]),
      .in_cnt_i     (chain_cnt[g]),
      .pass_valid_o (chain_v[g+1]),
      .pass_idx_o   (chain_idx[g+1]),
      .pass_cnt_o   (chain_cnt[g+1]),
      .held_idx_o   (held_idx[g]),
      .held_cnt_o   (held_cnt[g])
    );
  end

  // Control sequencer and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      sweep_q  <= '0;
      rank_q   <= '0;
      run_q    <= 1'b0;
      err_q    <= 1'b0;
      base_q   <= pch_pkg::TextBaseReset;
      en_q     <= 1'b0;
      word_q   <= '0;
      rd_v_q   <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == pch_pkg::RegTextBase) begin
          base_q <= {cfg_data_i[31:2], 2'b00};
        end else if (cfg_index_i == pch_pkg::RegSampleEn) begin
          en_q <= cfg_data_i[0];
        end
      end
      rd_v_q   <= (state_q == S_SCAN);
      rd_idx_q <= sweep_q[IdxW-1:0];
      case (state_q)
        S_INIT, S_CLR: begin
          sweep_q <= sweep_q + SwW'(1);
          if (sweep_q == SwW'(NUM_BINS - 1)) begin
            sweep_q <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            case (s_axis_tuser_i)
              pch_pkg::FuncSample: begin
                word_q <= offset[IdxW+1:2];
                if (en_q && in_window) begin
                  state_q <= S_RMW;
                end
              end
              pch_pkg::FuncClear: begin
                run_q   <= 1'b1;
                sweep_q <= '0;
                state_q <= S_CLR;
              end
              pch_pkg::FuncReport: begin
                rank_q  <= '0;
                err_q   <= !run_q;
                sweep_q <= '0;
                state_q <= run_q ? S_SCAN : S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_RMW: state_q <= S_IDLE;
        S_SCAN: begin
          sweep_q <= sweep_q + SwW'(1);
          if (sweep_q == SwW'(NUM_BINS - 1)) begin
            sweep_q <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          sweep_q <= sweep_q + SwW'(1);
          if (sweep_q == SwW'(K)) begin
            sweep_q <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_xfer) begin
            if (out_last) begin
              state_q <= S_IDLE;
            end else begin
              rank_q <= rank_q + RkW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result fields from the held cell contents
  logic [31:0]       hot_pc;
  logic [CntW-1:0]   hit_cnt;
  logic [RkOutW-1:0] rank_out;

  always_comb begin
    hot_pc   = base_q + {30'(held_idx[rank_q]), 2'b00};
    hit_cnt  = held_cnt[rank_q];
    rank_out = RkOutW'(rank_q);
    if (err_q) begin
      hot_pc   = '0;
      hit_cnt  = '0;
      rank_out = '0;
    end
  end

  assign m_axis_tvalid_o = (state_q == S_EMIT);
  assign m_axis_tdata_o  = {4'b0000, hit_cnt, hot_pc, rank_out};
  assign m_axis_tuser_o  = err_q ? pch_pkg::StatusNoRun : pch_pkg::StatusOk;
  assign m_axis_tlast_o  = out_last;

  `PCH_ASSERT_IMP(a_no_accept_while_out, m_axis_tvalid_o, !s_axis_tready_o,
                  "input accepted while a result is pending")
  `PCH_ASSERT_NXT(a_last_ends_report, out_xfer && m_axis_tlast_o, !m_axis_tvalid_o,
                  "result offered after the final transfer")
  `PCH_ASSERT_NXT(a_rmw_two_cycles, state_q == S_RMW, state_q == S_IDLE,
                  "bin update did not finish in two cycles")

endmodule
